[hw/rtl/tdp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared widths and types for the trial-division prime test core.
// ----------------------------------------------------------------------------
package tdp_pkg;

    // Width of the tested number
    localparam int NUM_W = 32;

    // Divider step counter: must hold NUM_W itself
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(NUM_W);

    // First odd trial divisor and divisor increment
    localparam logic [NUM_W-1:0] FIRST_DIVISOR = NUM_W'(3);
    localparam logic [NUM_W-1:0] DIVISOR_STEP  = NUM_W'(2);

    // Divider result, returned to the sequencer
    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
        logic [NUM_W-1:0] remainder;
    } div_res_t;

endpackage
`default_nettype wire

[hw/rtl/tdp_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_div
// Restoring divider, one quotient bit per cycle; quotient and remainder.
// ----------------------------------------------------------------------------
module tdp_div
    import tdp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [NUM_W-1:0] divisor,
    output div_res_t              res
);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [NUM_W:0]   shifted;
    logic [NUM_W:0]   diff;

    // Bring down the next dividend bit and trial-subtract the divisor
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (diff[NUM_W])
            begin
                rem_next = shifted[NUM_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[NUM_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule
`default_nettype wire

[hw/rtl/trial_division_prime_test_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// Tests one unsigned number per request for primality by trial division.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / candidate): one transfer carries
//   one number. Response channel (rsp_valid / rsp_stall / prime_flag): one
//   transfer per request, in order, prime_flag = 1 for a prime.
//   Numbers below 2, and even numbers, are answered without the divider:
//   the request goes straight to ST_DONE. Odd numbers of 3 and up run odd
//   divisors d = 3, 5, 7, ... through one shared restoring divider; each
//   divisor passes through a load, NUM_W quotient bits and a check. The loop
//   stops when d exceeds the quotient n / d or a remainder is zero, so a
//   32-bit prime near 2^32 takes about 32768 divisors. The divider sets the
//   rate.
//   req_stall is high while a number is in work; the block takes the next
//   request once its answer sits in the response register, even while that
//   response is still stalled.
//   A stalled response holds its value; a finished answer waits inside until
//   the response register is free. Reset (rst_n low, asynchronous) drops any
//   number in work and any pending response.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core
    import tdp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output      logic             req_stall,
    input  wire logic [NUM_W-1:0] candidate,
    output      logic             rsp_valid,
    input  wire logic             rsp_stall,
    output      logic             prime_flag
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] dvs_reg, dvs_next;
    logic             res_reg, res_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             flag_reg, flag_next;

    logic             req_xfer;
    logic             rsp_free;
    logic             div_start;
    div_res_t         div_res;

    assign req_xfer = req_valid && !req_stall;
    // Response register can take a new answer this cycle
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // Shared divider: n / d gives both the loop bound and the remainder
    tdp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (dvs_reg),
        .res      (div_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        dvs_next       = dvs_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        flag_next      = flag_reg;
        req_stall      = 1'b1;
        div_start      = 1'b0;

        // Drop the response once it transfers
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    num_next = candidate;
                    dvs_next = FIRST_DIVISOR;
                    if (candidate[NUM_W-1:1] == '0)
                    begin
                        // Zero and one
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (!candidate[0])
                    begin
                        // Even: prime only for two
                        res_next   = (candidate[NUM_W-1:2] == '0);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (dvs_reg > div_res.quotient)
                    begin
                        // d * d > n: no divisor left
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (div_res.remainder == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        dvs_next   = dvs_reg + DIVISOR_STEP;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_DONE:
            begin
                // Hold the answer until the response register frees up
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    flag_next      = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        dvs_reg  <= dvs_next;
        res_reg  <= res_next;
        flag_reg <= flag_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign prime_flag = flag_reg;

endmodule
`default_nettype wire

[hw/rtl/tdp_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_chk
// Port-level checks for the trial-division prime test core.
// ----------------------------------------------------------------------------
module tdp_chk
    import tdp_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_stall,
    input wire logic [NUM_W-1:0] candidate,
    input wire logic             rsp_valid,
    input wire logic             rsp_stall,
    input wire logic             prime_flag
);

    // A stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(prime_flag))
        else $error("stalled response changed");

    // The block is busy right after a request transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // Even numbers and zero, taken with no response pending, are answered via ST_DONE; only two is prime
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid && !candidate[0]
        |-> ##2 (rsp_valid && (prime_flag == ($past(candidate, 2) == NUM_W'(2)))))
        else $error("wrong or late answer for an even number");

    // A new response only follows a cycle in which the block was busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response appeared without work in progress");

endmodule

bind trial_division_prime_test_core tdp_chk u_tdp_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .candidate  (candidate),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .prime_flag (prime_flag)
);
`default_nettype wire

[test/tdp_prime_checker.sv]
// ----------------------------------------------------------------------------
// tdp_prime_checker
// Watches both channels of the prime test core, works out the expected flag
// for every request transfer and compares each response transfer against it.
// ----------------------------------------------------------------------------
module tdp_prime_checker
    import tdp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire logic             req_stall,
    input  wire logic [NUM_W-1:0] candidate,
    input  wire logic             rsp_valid,
    input  wire logic             rsp_stall,
    input  wire logic             prime_flag,
    output int unsigned           failures,
    output int unsigned           outstanding
);

    typedef struct {
        logic [NUM_W-1:0] number;
        logic             flag;
    } verdict_t;

    verdict_t    expected_verdicts[$];
    int unsigned rsp_index;

    // Odd divisors from 3 while d <= n / d, so d * d never has to be formed.
    function automatic logic predict_prime(input logic [NUM_W-1:0] n);
        logic [NUM_W-1:0] d;
        if (n < 2)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        for (d = 3; d <= n / d; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] response %0d: %s", $time, rsp_index, what);
        failures++;
    endtask

    initial
    begin
        failures    = 0;
        outstanding = 0;
        rsp_index   = 0;
    end

    always @(posedge clk)
    begin : watch
        verdict_t head;
        verdict_t fresh;
        if (rst_n)
        begin
            // Retire before queueing, so a stray response never eats this cycle's request.
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch("response transfer with no request waiting");
                else
                begin
                    head = expected_verdicts.pop_front();
                    if (prime_flag !== head.flag)
                        report_mismatch($sformatf("candidate %0d (0x%08h): prime_flag %b, want %b",
                                                  head.number, head.number, prime_flag,
                                                  head.flag));
                end
                rsp_index++;
            end
            if (req_valid && !req_stall)
            begin
                fresh.number = candidate;
                fresh.flag   = predict_prime(candidate);
                expected_verdicts.push_back(fresh);
            end
            outstanding = expected_verdicts.size();
        end
    end

endmodule

[test/trial_division_prime_test_core_tb.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test_core_tb
// Regression for the trial-division prime test core. A directed pass covers
// zero, one, two, even numbers, odd squares, small and large primes and the
// extremes of the 32-bit range; a random pass follows with mostly small
// numbers and large numbers that carry a small factor. Both channels idle at
// random, and the response side holds off once long enough to back the core
// up. A checker beside the core predicts and compares every response.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core_tb;
    import tdp_pkg::*;

    // A 32-bit prime near the top of the range is by far the longest run;
    // everything else in the run is small. Several times the expected total.
    localparam int unsigned CYCLE_LIMIT   = 6_000_000;
    localparam int unsigned RANDOM_ITEMS  = 100;
    localparam int unsigned PRESSURE_AT   = 30;    // request transfers before the long hold
    localparam int unsigned HOLD_CYCLES   = 3000;  // covers two slow small items plus a third
    localparam int unsigned DRAIN_CYCLES  = 200;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             req_valid  = 1'b0;
    logic             req_stall;
    logic [NUM_W-1:0] candidate  = '0;
    logic             rsp_valid;
    logic             rsp_stall  = 1'b0;
    logic             prime_flag;

    int unsigned failures;
    int unsigned outstanding;
    int unsigned req_count     = 0;
    int unsigned req_idle_pct  = 0;
    int unsigned cycle_count   = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    trial_division_prime_test_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .candidate  (candidate),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .prime_flag (prime_flag)
    );

    tdp_prime_checker u_prime_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .candidate   (candidate),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .prime_flag  (prime_flag),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // Idle rate for a stretch: none at all, light, or heavy.
    function automatic int unsigned pick_idle_pct();
        int unsigned sel;
        sel = $urandom_range(0, 2);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return 20;
        return 50;
    endfunction

    // Gap length: mostly short, now and then a long one.
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    // Keep the divisor loop short: small numbers dominate, large numbers are
    // even or carry an odd factor below 64, and odd squares hit the d*d == n bound.
    function automatic logic [NUM_W-1:0] random_candidate();
        int unsigned pick;
        int unsigned factor;
        int unsigned root;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return NUM_W'($urandom_range(0, 4095));
        if (pick < 60)
            return NUM_W'($urandom_range(0, 65535));
        if (pick < 75)
            return NUM_W'($urandom) & ~NUM_W'(1);
        if (pick < 95)
        begin
            factor = 2 * $urandom_range(1, 31) + 1;
            return NUM_W'(factor * $urandom_range(1, 32'hFFFF_FFFF / factor));
        end
        root = 2 * $urandom_range(1, 127) + 1;
        return NUM_W'(root * root);
    endfunction

    // Offer one number and hold it until the core takes it. Entered and left
    // on a rising edge; valid stays high into the next call unless it idles.
    task automatic send_candidate(input logic [NUM_W-1:0] n);
        if (req_count % 16 == 0)
            req_idle_pct = pick_idle_pct();
        if ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
        req_valid <= 1'b1;
        candidate <= n;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        req_count++;
    endtask

    // Response side: random stalls in stretches, plus one long hold-off once
    // the random pass is under way so the core fills and stalls its input.
    initial
    begin : response_side
        int unsigned rsp_idle_pct;
        int unsigned beats;
        logic        pressure_done;
        rsp_idle_pct  = 0;
        beats         = 0;
        pressure_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            beats++;
            if (beats % 64 == 0)
                rsp_idle_pct = pick_idle_pct();
            if (!pressure_done && req_count >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < rsp_idle_pct)
            begin
                rsp_stall <= 1'b1;
                repeat (idle_len() - 1) @(posedge clk);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Hard stop if the core hangs.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("trial_division_prime_test_core regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned i;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Below two, two itself, the first odd primes and an even number
        send_candidate(NUM_W'(0));
        send_candidate(NUM_W'(1));
        send_candidate(NUM_W'(2));
        send_candidate(NUM_W'(3));
        send_candidate(NUM_W'(4));
        send_candidate(NUM_W'(5));
        // Odd squares, where the last divisor tried is exactly the root, and 15
        send_candidate(NUM_W'(9));
        send_candidate(NUM_W'(15));
        send_candidate(NUM_W'(25));
        send_candidate(NUM_W'(49));
        send_candidate(NUM_W'(121));
        send_candidate(NUM_W'(63001));       // 251 squared
        // Primes of growing size
        send_candidate(NUM_W'(65521));
        send_candidate(NUM_W'(65537));
        send_candidate(NUM_W'(1000003));
        // Extremes of the field: all ones (divisible by 3), top bit alone,
        // alternating patterns, and the largest 32-bit prime (the long run)
        send_candidate(32'hFFFF_FFFF);
        send_candidate(32'hFFFF_FFFE);
        send_candidate(32'h8000_0000);
        send_candidate(32'h5555_5555);
        send_candidate(32'hAAAA_AAAA);
        send_candidate(32'd4294967291);

        for (i = 0; i < RANDOM_ITEMS; i++)
            send_candidate(random_candidate());

        // Drop valid, let the checker log the last transfer, wait out every
        // response, then give stray ones time to show.
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("trial_division_prime_test_core regression: pass");
        else
            $display("trial_division_prime_test_core regression: fail");
        $finish;
    end

endmodule

[trial_division_prime_test_core.f]
hw/rtl/tdp_pkg.sv
hw/rtl/tdp_div.sv
hw/rtl/trial_division_prime_test_core.sv
hw/rtl/tdp_chk.sv
test/tdp_prime_checker.sv
test/trial_division_prime_test_core_tb.sv
